// ===== hdl/waveform_min_peak_envelope_top_defines.svh =====
// Assertion macros shared by the envelope checker.
`ifndef WAVEFORM_MIN_PEAK_ENVELOPE_TOP_DEFINES_SVH
`define WAVEFORM_MIN_PEAK_ENVELOPE_TOP_DEFINES_SVH

// Same-cycle implication.
`define WMPE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define WMPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/wmpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpe_pkg
// Shared widths, register map, reset values and pipeline types of the
// min/peak waveform envelope block.
// ----------------------------------------------------------------------------
package wmpe_pkg;

   // Pixel value width; height register and result values share it.
   localparam int VALUE_WIDTH  = 12;
   localparam int SAMPLE_WIDTH = 16;
   localparam int AMP_WIDTH    = 16;
   localparam int SPC_WIDTH    = 16;
   localparam int COLS_WIDTH   = 13;
   localparam int COL_WIDTH    = 12;
   localparam int CHANS_WIDTH  = 4;
   localparam int POS_WIDTH    = 3;
   localparam int MAX_CHANS    = 8;
   localparam int MAX_COLS     = 4096;

   // Multiplier operands are 17-bit signed, product fits 32 bits signed.
   localparam int OPER_WIDTH   = SAMPLE_WIDTH + 1;
   localparam int PROD_WIDTH   = 32;
   localparam int BYTE_PROD_WIDTH = 8 + AMP_WIDTH;
   localparam int QUOT_WIDTH   = 17;
   localparam int DIFF_WIDTH   = 19;
   localparam int BYTE_DIVISOR = 'hFF;
   localparam int HALF_SHIFT   = 15;   // divide by 0x8000

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [2:0] {
      REG_SAMPLE_FORMAT      = 3'd0,
      REG_HEIGHT             = 3'd1,
      REG_AMPLITUDE          = 3'd2,
      REG_SAMPLES_PER_COLUMN = 3'd3,
      REG_COLUMN_COUNT       = 3'd4,
      REG_CHANNEL_COUNT      = 3'd5
   } reg_index_type;

   typedef enum logic {
      FORMAT_U8  = 1'b0,
      FORMAT_S16 = 1'b1
   } format_type;

   localparam format_type            RESET_FORMAT = FORMAT_S16;
   localparam logic [VALUE_WIDTH-1:0] RESET_HEIGHT = VALUE_WIDTH'(256);
   localparam logic [AMP_WIDTH-1:0]   RESET_AMP    = AMP_WIDTH'(128);
   localparam logic [SPC_WIDTH-1:0]   RESET_SPC    = SPC_WIDTH'(1);
   localparam logic [COLS_WIDTH-1:0]  RESET_COLS   = COLS_WIDTH'(1024);
   localparam logic [CHANS_WIDTH-1:0] RESET_CHANS  = CHANS_WIDTH'(1);

   typedef struct packed {
      format_type             sample_format;
      logic [VALUE_WIDTH-1:0] height;
      logic [AMP_WIDTH-1:0]   amplitude;
      logic [SPC_WIDTH-1:0]   samples_per_column;
      logic [COLS_WIDTH-1:0]  column_count;
      logic [CHANS_WIDTH-1:0] channel_count;
   } cfg_type;

   // Column bookkeeping that travels with each channel-0 sample.
   typedef struct packed {
      logic                 clear;      // pass starts here: restart min/peak
      logic                 emit;       // sample closes its column
      logic                 last;       // closed column is the final one
      logic [COL_WIDTH-1:0] column;
   } tag_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] sample;
      tag_type                 tag;
   } item_type;

endpackage

// ===== hdl/wmpe_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpe_req_if
// Sample channel: one interleaved audio sample per transfer.
// ----------------------------------------------------------------------------
interface wmpe_req_if;
   logic                              valid;
   logic                              ready;
   logic [wmpe_pkg::SAMPLE_WIDTH-1:0] sample;
   logic                              start_pass;

   modport source (output valid, output sample, output start_pass, input ready);
   modport sink   (input valid, input sample, input start_pass, output ready);
endinterface

// ===== hdl/wmpe_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpe_rsp_if
// Column channel: one finished display column per transfer.
// ----------------------------------------------------------------------------
interface wmpe_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [wmpe_pkg::COL_WIDTH-1:0]   column_index;
   logic [wmpe_pkg::VALUE_WIDTH-1:0] low_value;
   logic [wmpe_pkg::VALUE_WIDTH-1:0] high_value;
   logic                             last_column;

   modport source (output valid, output column_index, output low_value,
                   output high_value, output last_column, input ready);
   modport sink   (input valid, input column_index, input low_value,
                   input high_value, input last_column, output ready);
endinterface

// ===== hdl/wmpe_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpe_csr
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module wmpe_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wmpe_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [wmpe_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [wmpe_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output wmpe_pkg::cfg_type                   cfg
);
   import wmpe_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_SAMPLE_FORMAT:      cfg_in.sample_format = format_type'(csr_pwdata[0]);
            REG_HEIGHT:             cfg_in.height = csr_pwdata[VALUE_WIDTH-1:0];
            REG_AMPLITUDE:          cfg_in.amplitude = csr_pwdata[AMP_WIDTH-1:0];
            REG_SAMPLES_PER_COLUMN: cfg_in.samples_per_column = csr_pwdata[SPC_WIDTH-1:0];
            REG_COLUMN_COUNT:       cfg_in.column_count = csr_pwdata[COLS_WIDTH-1:0];
            REG_CHANNEL_COUNT:      cfg_in.channel_count = csr_pwdata[CHANS_WIDTH-1:0];
            default:                cfg_in = cfg_ff;   // unmapped: drop
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_SAMPLE_FORMAT:      csr_prdata = CSR_DATA_WIDTH'(cfg_ff.sample_format);
         REG_HEIGHT:             csr_prdata = CSR_DATA_WIDTH'(cfg_ff.height);
         REG_AMPLITUDE:          csr_prdata = CSR_DATA_WIDTH'(cfg_ff.amplitude);
         REG_SAMPLES_PER_COLUMN: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.samples_per_column);
         REG_COLUMN_COUNT:       csr_prdata = CSR_DATA_WIDTH'(cfg_ff.column_count);
         REG_CHANNEL_COUNT:      csr_prdata = CSR_DATA_WIDTH'(cfg_ff.channel_count);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_format      <= RESET_FORMAT;
         cfg_ff.height             <= RESET_HEIGHT;
         cfg_ff.amplitude          <= RESET_AMP;
         cfg_ff.samples_per_column <= RESET_SPC;
         cfg_ff.column_count       <= RESET_COLS;
         cfg_ff.channel_count      <= RESET_CHANS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// ===== hdl/wmpe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpe_ctrl
// Channel, sample-in-column and column counters; tags each channel-0 sample.
// ----------------------------------------------------------------------------
module wmpe_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  wmpe_pkg::cfg_type                 cfg,
   input  logic                              accept,
   input  logic [wmpe_pkg::SAMPLE_WIDTH-1:0] sample,
   input  logic                              start_pass,
   output logic                              item_valid,
   output wmpe_pkg::item_type                item
);
   import wmpe_pkg::*;

   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [SPC_WIDTH-1:0]   sic_ff, sic_in;
   logic [COL_WIDTH-1:0]   col_ff, col_in;

   logic [POS_WIDTH-1:0]   pos_base;
   logic [SPC_WIDTH-1:0]   sic_base;
   logic [COL_WIDTH-1:0]   col_base;
   logic [CHANS_WIDTH-1:0] chans;
   logic [CHANS_WIDTH-1:0] pos_inc;
   logic [SPC_WIDTH-1:0]   spc;
   logic [SPC_WIDTH:0]     sic_inc;
   logic [COLS_WIDTH-1:0]  cols;
   logic [COLS_WIDTH-1:0]  col_inc;
   logic                   is_ch0;
   logic                   col_done;
   logic                   last;

   always_comb begin
      // a new pass clears all counters before this sample counts
      pos_base = start_pass ? '0 : pos_ff;
      sic_base = start_pass ? '0 : sic_ff;
      col_base = start_pass ? '0 : col_ff;

      if (cfg.channel_count == '0)
         chans = CHANS_WIDTH'(1);
      else if (cfg.channel_count > CHANS_WIDTH'(MAX_CHANS))
         chans = CHANS_WIDTH'(MAX_CHANS);
      else
         chans = cfg.channel_count;

      spc = (cfg.samples_per_column == '0) ? SPC_WIDTH'(1) : cfg.samples_per_column;

      if (cfg.column_count == '0)
         cols = COLS_WIDTH'(1);
      else if (cfg.column_count > COLS_WIDTH'(MAX_COLS))
         cols = COLS_WIDTH'(MAX_COLS);
      else
         cols = cfg.column_count;

      pos_inc  = CHANS_WIDTH'(pos_base) + CHANS_WIDTH'(1);
      is_ch0   = (pos_base == '0);
      sic_inc  = {1'b0, sic_base} + (SPC_WIDTH+1)'(1);
      col_done = (sic_inc >= {1'b0, spc});
      col_inc  = {1'b0, col_base} + COLS_WIDTH'(1);
      last     = (col_inc >= cols);

      pos_in = pos_ff;
      sic_in = sic_ff;
      col_in = col_ff;
      if (accept) begin
         pos_in = (pos_inc >= chans) ? '0 : pos_inc[POS_WIDTH-1:0];
         sic_in = sic_base;
         col_in = col_base;
         if (is_ch0) begin
            if (col_done) begin
               sic_in = '0;
               col_in = last ? '0 : col_inc[COL_WIDTH-1:0];
            end else begin
               sic_in = sic_inc[SPC_WIDTH-1:0];
            end
         end
      end
   end

   // only channel-0 samples travel on
   assign item_valid      = accept && is_ch0;
   assign item.sample     = sample;
   assign item.tag.clear  = start_pass;
   assign item.tag.emit   = col_done;
   assign item.tag.last   = last;
   assign item.tag.column = col_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sic_ff <= '0;
         col_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sic_ff <= sic_in;
         col_ff <= col_in;
      end
   end
endmodule

// ===== hdl/wmpe_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpe_scale
// Three-stage sample-to-pixel conversion: input register, gain product,
// constant divide with offset and clamp to 0..height.
// ----------------------------------------------------------------------------
module wmpe_scale (
   input  logic                             clock,
   input  logic                             reset,
   input  wmpe_pkg::cfg_type                cfg,
   input  logic                             in_valid,
   input  wmpe_pkg::item_type               in_item,
   output logic                             in_ready,
   output logic                             out_valid,
   output logic [wmpe_pkg::VALUE_WIDTH-1:0] out_value,
   output wmpe_pkg::tag_type                out_tag,
   input  logic                             out_ready
);
   import wmpe_pkg::*;

   localparam logic signed [PROD_WIDTH-1:0] TRUNC_BIAS =
      PROD_WIDTH'((1 << HALF_SHIFT) - 1);

   logic                           s1_valid_ff;
   logic [SAMPLE_WIDTH-1:0]        s1_sample_ff;
   tag_type                        s1_tag_ff;
   logic                           s2_valid_ff;
   logic signed [PROD_WIDTH-1:0]   s2_prod_ff;
   tag_type                        s2_tag_ff;
   logic                           s3_valid_ff;
   logic [VALUE_WIDTH-1:0]         s3_value_ff;
   tag_type                        s3_tag_ff;

   logic                           s1_ready, s2_ready, s3_ready;
   logic signed [OPER_WIDTH-1:0]   op_sample;
   logic signed [OPER_WIDTH-1:0]   op_amp;
   logic signed [2*OPER_WIDTH-1:0] prod_full;
   logic signed [PROD_WIDTH-1:0]   s2_prod_in;

   logic [BYTE_PROD_WIDTH-1:0]     byte_prod;
   logic [BYTE_PROD_WIDTH:0]       byte_sum;
   logic [QUOT_WIDTH-1:0]          byte_q0;
   logic [BYTE_PROD_WIDTH:0]       byte_back;
   logic [BYTE_PROD_WIDTH:0]       byte_rem;
   logic [QUOT_WIDTH-1:0]          byte_q;
   logic signed [PROD_WIDTH-1:0]   biased;
   logic signed [QUOT_WIDTH-1:0]   word_q;
   logic signed [DIFF_WIDTH-1:0]   diff;
   logic signed [DIFF_WIDTH-1:0]   height_s;
   logic [VALUE_WIDTH-1:0]         s3_value_in;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // gain product: signed 17 x 17
   always_comb begin
      if (cfg.sample_format == FORMAT_S16)
         op_sample = {s1_sample_ff[SAMPLE_WIDTH-1], s1_sample_ff};
      else
         op_sample = {{(OPER_WIDTH-8){1'b0}}, s1_sample_ff[7:0]};
      op_amp     = {1'b0, cfg.amplitude};
      prod_full  = op_sample * op_amp;
      s2_prod_in = prod_full[PROD_WIDTH-1:0];
   end

   // divide, offset and clamp
   always_comb begin
      // floor(p / 255): estimate from p * (1 + 2^-8 + 2^-16) / 256, then fix by one
      byte_prod = s2_prod_ff[BYTE_PROD_WIDTH-1:0];
      byte_sum  = {1'b0, byte_prod} + (BYTE_PROD_WIDTH+1)'(byte_prod >> 8)
                  + (BYTE_PROD_WIDTH+1)'(byte_prod >> 16);
      byte_q0   = byte_sum[BYTE_PROD_WIDTH:8];
      byte_back = {byte_q0, 8'b0} - (BYTE_PROD_WIDTH+1)'(byte_q0);
      byte_rem  = {1'b0, byte_prod} - byte_back;
      byte_q    = (byte_rem >= (BYTE_PROD_WIDTH+1)'(BYTE_DIVISOR)) ?
                  byte_q0 + QUOT_WIDTH'(1) : byte_q0;

      // p / 32768 rounding toward zero: bias negatives before the shift
      biased = s2_prod_ff + (s2_prod_ff[PROD_WIDTH-1] ? TRUNC_BIAS : '0);
      word_q = QUOT_WIDTH'(biased >>> HALF_SHIFT);

      height_s = $signed({{(DIFF_WIDTH-VALUE_WIDTH){1'b0}}, cfg.height});
      if (cfg.sample_format == FORMAT_S16)
         diff = (height_s >>> 1) - DIFF_WIDTH'(word_q);
      else
         diff = height_s - $signed({{(DIFF_WIDTH-QUOT_WIDTH){1'b0}}, byte_q});

      if (diff < 0)
         s3_value_in = '0;
      else if (diff > height_s)
         s3_value_in = cfg.height;
      else
         s3_value_in = diff[VALUE_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_sample_ff <= in_item.sample;
         s1_tag_ff    <= in_item.tag;
      end
      if (s2_ready) begin
         s2_prod_ff <= s2_prod_in;
         s2_tag_ff  <= s1_tag_ff;
      end
      if (s3_ready) begin
         s3_value_ff <= s3_value_in;
         s3_tag_ff   <= s2_tag_ff;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_value = s3_value_ff;
   assign out_tag   = s3_tag_ff;
endmodule

// ===== hdl/wmpe_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpe_accum
// Running minimum and peak of the open column, and the result register.
// ----------------------------------------------------------------------------
module wmpe_accum (
   input  logic                             clock,
   input  logic                             reset,
   input  wmpe_pkg::cfg_type                cfg,
   input  logic                             in_valid,
   input  logic [wmpe_pkg::VALUE_WIDTH-1:0] in_value,
   input  wmpe_pkg::tag_type                in_tag,
   output logic                             in_ready,
   wmpe_rsp_if.source                       rsp_chan
);
   import wmpe_pkg::*;

   logic [VALUE_WIDTH-1:0] min_ff, min_in;
   logic [VALUE_WIDTH-1:0] peak_ff, peak_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COL_WIDTH-1:0]   rsp_column_ff;
   logic [VALUE_WIDTH-1:0] rsp_low_ff;
   logic [VALUE_WIDTH-1:0] rsp_high_ff;
   logic                   rsp_last_ff;

   logic [VALUE_WIDTH-1:0] base_min, base_peak;
   logic [VALUE_WIDTH-1:0] new_min, new_peak;
   logic                   out_free;
   logic                   take;
   logic                   load_rsp;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   // only a column-closing sample needs the result register free
   assign in_ready = !in_tag.emit || out_free;
   assign take     = in_valid && in_ready;
   assign load_rsp = take && in_tag.emit;

   always_comb begin
      base_min  = in_tag.clear ? cfg.height : min_ff;
      base_peak = in_tag.clear ? '0 : peak_ff;
      new_min   = (in_value < base_min) ? in_value : base_min;
      new_peak  = (in_value > base_peak) ? in_value : base_peak;

      min_in  = min_ff;
      peak_in = peak_ff;
      if (take) begin
         if (in_tag.emit) begin
            min_in  = cfg.height;
            peak_in = '0;
         end else begin
            min_in  = new_min;
            peak_in = new_peak;
         end
      end

      if (load_rsp)
         rsp_valid_in = 1'b1;
      else if (rsp_chan.ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= RESET_HEIGHT;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_ff       <= min_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_column_ff <= in_tag.column;
         rsp_low_ff    <= new_min;
         rsp_high_ff   <= new_peak;
         rsp_last_ff   <= in_tag.last;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.column_index = rsp_column_ff;
   assign rsp_chan.low_value    = rsp_low_ff;
   assign rsp_chan.high_value   = rsp_high_ff;
   assign rsp_chan.last_column  = rsp_last_ff;
endmodule

// ===== hdl/waveform_min_peak_envelope_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_min_peak_envelope_top
// Min/peak display envelope of channel 0 of an interleaved sample stream.
//
//   channel   | dir | carries
//   ----------+-----+----------------------------------------------------
//   req_chan  | in  | sample, start_pass (one interleaved sample)
//   rsp_chan  | out | column_index, low_value, high_value, last_column
//   csr_*     | in  | APB-style register writes and reads, pready tied high
//
// One sample is taken every cycle while the conversion pipeline can accept it;
// a sample that closes a column reaches the result register through the
// input register, which loads at the transfer, then the product, value and
// result registers. A waiting result only stalls intake when the next
// column-closing sample reaches the accumulator; back pressure then fills
// the three conversion registers in turn. Synchronous reset restores the
// register defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module waveform_min_peak_envelope_top (
   input  logic                                clock,
   input  logic                                reset,
   wmpe_req_if.sink                            req_chan,
   wmpe_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wmpe_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [wmpe_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [wmpe_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import wmpe_pkg::*;

   cfg_type                cfg;
   logic                   accept;
   logic                   item_valid;
   item_type               item;
   logic                   scale_ready;
   logic                   value_valid;
   logic [VALUE_WIDTH-1:0] value;
   tag_type                value_tag;
   logic                   acc_ready;

   assign req_chan.ready = scale_ready;
   assign accept         = req_chan.valid && scale_ready;

   wmpe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wmpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (accept),
      .sample     (req_chan.sample),
      .start_pass (req_chan.start_pass),
      .item_valid (item_valid),
      .item       (item)
   );

   wmpe_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (item_valid),
      .in_item   (item),
      .in_ready  (scale_ready),
      .out_valid (value_valid),
      .out_value (value),
      .out_tag   (value_tag),
      .out_ready (acc_ready)
   );

   wmpe_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (value_valid),
      .in_value (value),
      .in_tag   (value_tag),
      .in_ready (acc_ready),
      .rsp_chan (rsp_chan)
   );
endmodule

// ===== hdl/wmpe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpe_checker
// Port-level checks of the envelope block, bound to the top level.
// ----------------------------------------------------------------------------
`include "waveform_min_peak_envelope_top_defines.svh"

module wmpe_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [wmpe_pkg::COL_WIDTH-1:0]   rsp_column_index,
   input logic [wmpe_pkg::VALUE_WIDTH-1:0] rsp_low_value,
   input logic [wmpe_pkg::VALUE_WIDTH-1:0] rsp_high_value,
   input logic                             rsp_last_column
);
   // every column holds at least one value, so its minimum cannot pass its peak
   `WMPE_ASSERT_SAME(a_low_not_above_high, clock, reset, rsp_valid, rsp_low_value <= rsp_high_value, "column low value above high value")

   // with the result register empty nothing downstream can block intake
   `WMPE_ASSERT_SAME(a_ready_when_drained, clock, reset, !rsp_valid, req_ready, "sample channel stalled with no result pending")

   `WMPE_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid, "result still offered after reset")

   // hold the offered column until its transfer
   `WMPE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_column_index) && $stable(rsp_low_value) && $stable(rsp_high_value) && $stable(rsp_last_column), "stalled result changed")
endmodule

bind waveform_min_peak_envelope_top wmpe_checker u_wmpe_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_column_index (rsp_chan.column_index),
   .rsp_low_value    (rsp_chan.low_value),
   .rsp_high_value   (rsp_chan.high_value),
   .rsp_last_column  (rsp_chan.last_column)
);
